// ===== hdl/anbs_pkg.sv =====
package anbs_pkg;

    localparam int LOOKAHEAD = 5;
    localparam int BYTE_W = 8;
    localparam int STAMP_W = 63;
    localparam int TDATA_W = 72;
    localparam int COUNT_W = 3;

    localparam logic [2:0] CODE_LONG = 3'd4;
    localparam logic [2:0] CODE_SHORT = 3'd3;
    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [2:0] OFFSET_MAX = 3'd7;

    localparam logic [5:0] VCL_LOW_MAX = 6'd9;
    localparam logic [5:0] VCL_HIGH_MIN = 6'd16;
    localparam logic [5:0] VCL_HIGH_MAX = 6'd21;
    localparam logic [7:0] NAL_TYPE_MASK = 8'h7E;
    localparam logic [7:0] FIRST_SLICE_MASK = 8'h80;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_H264     = 2'd1,
        MODE_H265     = 2'd2,
        MODE_H265_ALT = 2'd3
    } mode_t;

    // bytes of one group leave in index order, tail_end marks the final one
    typedef struct packed {
        byte_t [LOOKAHEAD-1:0] bytes;
        logic [COUNT_W-1:0]    count;
        logic                  tail_end;
        stamp_t                stamp;
    } group_t;

    function automatic logic [2:0] start_code_len(input byte_t b0, input byte_t b1,
                                                  input byte_t b2, input byte_t b3);
        logic [2:0] len;
        len = CODE_NONE;
        if (b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h00 && b3 == 8'h01) begin
            len = CODE_LONG;
        end else if (b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h01) begin
            len = CODE_SHORT;
        end
        return len;
    endfunction

    function automatic logic is_vcl(input logic [5:0] t);
        return (t <= VCL_LOW_MAX) || (t >= VCL_HIGH_MIN && t <= VCL_HIGH_MAX);
    endfunction

endpackage

// ===== hdl/anbs_front.sv =====
module anbs_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_wr_data,
    input  logic                   in_fire,
    input  anbs_pkg::byte_t        data_byte,
    input  logic                   buffer_last,
    input  anbs_pkg::stamp_t       stamp,
    output logic                   push,
    output anbs_pkg::group_t       group
);
    import anbs_pkg::*;

    mode_t       codec_mode_reg, codec_mode_next;
    mode_t       active_mode_reg, active_mode_next;
    logic        mid_buffer_reg, mid_buffer_next;
    byte_t       window_reg [LOOKAHEAD-1];
    byte_t       window_next [LOOKAHEAD-1];
    logic [2:0]  fill_reg, fill_next;
    logic        found_reg, found_next;
    logic [2:0]  code_len_reg, code_len_next;
    logic [2:0]  offset_reg, offset_next;
    logic        merge_reg, merge_next;

    mode_t       act;
    byte_t       cur [LOOKAHEAD];
    logic [2:0]  fill_inc;
    logic        sel;
    byte_t       s0, s1, s2, s3;
    logic [2:0]  len;
    logic [2:0]  pkt_dist;
    logic        merge_v;
    logic        new_start;

    always_comb begin
        codec_mode_next = cfg_wr_en ? mode_t'(cfg_wr_data) : codec_mode_reg;
        act = mid_buffer_reg ? active_mode_reg : codec_mode_reg;
        fill_inc = fill_reg + 3'd1;
        for (int k = 0; k < LOOKAHEAD - 1; k++) begin
            if (3'(k) < fill_reg) begin
                cur[k] = window_reg[k];
            end else if (3'(k) == fill_reg) begin
                cur[k] = data_byte;
            end else begin
                cur[k] = '0;
            end
        end
        cur[LOOKAHEAD-1] = (fill_reg == 3'(LOOKAHEAD - 1)) ? data_byte : '0;
        sel = (fill_inc == 3'(LOOKAHEAD));
        s0 = sel ? cur[1] : cur[0];
        s1 = sel ? cur[2] : cur[1];
        s2 = sel ? cur[3] : cur[2];
        s3 = sel ? cur[4] : cur[3];
        len = start_code_len(s0, s1, s2, s3);
        pkt_dist = (offset_reg < OFFSET_MAX) ? offset_reg + 3'd1 : OFFSET_MAX;
        merge_v = merge_reg;
        if (act != MODE_H264 && pkt_dist == code_len_reg && !merge_reg
                && is_vcl(6'((s0 & NAL_TYPE_MASK) >> 1))
                && (s2 & FIRST_SLICE_MASK) != 8'h00) begin
            merge_v = 1'b1;
        end
        new_start = found_reg && !merge_v && pkt_dist >= code_len_reg && len != CODE_NONE;

        active_mode_next = active_mode_reg;
        mid_buffer_next = mid_buffer_reg;
        for (int k = 0; k < LOOKAHEAD - 1; k++) begin
            window_next[k] = window_reg[k];
        end
        fill_next = fill_reg;
        found_next = found_reg;
        code_len_next = code_len_reg;
        offset_next = offset_reg;
        merge_next = merge_reg;
        group = '0;
        group.stamp = stamp;

        if (in_fire) begin
            active_mode_next = act;
            mid_buffer_next = !buffer_last;
            if (act == MODE_PASS) begin
                group.bytes[0] = data_byte;
                group.count = 3'd1;
                group.tail_end = buffer_last;
            end else if (!buffer_last) begin
                if (fill_inc >= 3'(LOOKAHEAD - 1)) begin
                    if (!found_reg) begin
                        if (len != CODE_NONE) begin
                            found_next = 1'b1;
                            code_len_next = len;
                            offset_next = '0;
                        end
                    end else begin
                        offset_next = pkt_dist;
                        merge_next = merge_v;
                        if (new_start) begin
                            code_len_next = len;
                            offset_next = '0;
                        end
                    end
                end
                if (sel) begin
                    if (found_reg) begin
                        group.bytes[0] = cur[0];
                        group.count = 3'd1;
                        group.tail_end = new_start;
                    end
                    for (int k = 0; k < LOOKAHEAD - 1; k++) begin
                        window_next[k] = cur[k+1];
                    end
                    fill_next = 3'(LOOKAHEAD - 1);
                end else begin
                    for (int k = 0; k < LOOKAHEAD - 1; k++) begin
                        window_next[k] = cur[k];
                    end
                    fill_next = fill_inc;
                end
            end else begin
                if (!found_reg && sel) begin
                    for (int k = 0; k < LOOKAHEAD - 1; k++) begin
                        group.bytes[k] = cur[k+1];
                    end
                    group.count = 3'(LOOKAHEAD - 1);
                end else begin
                    for (int k = 0; k < LOOKAHEAD; k++) begin
                        group.bytes[k] = cur[k];
                    end
                    group.count = fill_inc;
                end
                group.tail_end = 1'b1;
                fill_next = '0;
                found_next = 1'b0;
                code_len_next = '0;
                offset_next = '0;
                merge_next = 1'b0;
            end
        end
        push = in_fire && group.count != '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_mode_reg <= MODE_PASS;
            active_mode_reg <= MODE_PASS;
            mid_buffer_reg <= 1'b0;
            fill_reg <= '0;
            found_reg <= 1'b0;
            code_len_reg <= '0;
            offset_reg <= '0;
            merge_reg <= 1'b0;
        end else begin
            codec_mode_reg <= codec_mode_next;
            active_mode_reg <= active_mode_next;
            mid_buffer_reg <= mid_buffer_next;
            fill_reg <= fill_next;
            found_reg <= found_next;
            code_len_reg <= code_len_next;
            offset_reg <= offset_next;
            merge_reg <= merge_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < LOOKAHEAD - 1; k++) begin
            window_reg[k] <= window_next[k];
        end
    end

endmodule

// ===== hdl/anbs_queue.sv =====
module anbs_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  anbs_pkg::group_t  wr_group,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output anbs_pkg::group_t  rd_group
);
    import anbs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    group_t          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb begin
        full = (count_reg == CW'(DEPTH));
        not_empty = (count_reg != '0);
        rd_group = mem[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_group;
        end
    end

endmodule

// ===== hdl/anbs_back.sv =====
module anbs_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  anbs_pkg::group_t                    q_group,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [anbs_pkg::TDATA_W-1:0]        m_tdata,  // out_byte, out_stamp, zero pad
    output logic                                m_tlast   // packet_end
);
    import anbs_pkg::*;

    logic                busy_reg, busy_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    group_t              group_reg;
    logic                out_fire;
    logic                last_beat;

    always_comb begin
        out_fire = busy_reg && m_tready;
        last_beat = (idx_reg == group_reg.count - COUNT_W'(1));
        q_pop = q_valid && (!busy_reg || (out_fire && last_beat));
        busy_next = busy_reg;
        idx_next = idx_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            idx_next = '0;
        end else if (out_fire) begin
            if (last_beat) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + COUNT_W'(1);
            end
        end
        m_tvalid = busy_reg;
        m_tdata = {1'b0, group_reg.stamp, group_reg.bytes[idx_reg]};
        m_tlast = group_reg.tail_end && last_beat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            group_reg <= q_group;
        end
    end

endmodule

// ===== hdl/annexb_nal_splitter.sv =====
// output path: a byte's group is queued once its packet position is resolved (in split
// modes, when the fourth byte after it arrives or at buffer end), then popped into a register
// throughput: one byte per cycle in, and out while m_tready is high; a buffer's last byte
// releases up to five bytes, drained one per cycle; s_tready drops only when the queue fills
// reset: synchronous active-low aresetn clears all control state, mode returns to pass-through
module annexb_nal_splitter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_wr_data,  // codec_mode
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [anbs_pkg::TDATA_W-1:0]  s_tdata,      // data_byte, stamp, zero pad
    input  logic                          s_tlast,      // buffer_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [anbs_pkg::TDATA_W-1:0]  m_tdata,      // out_byte, out_stamp, zero pad
    output logic                          m_tlast       // packet_end
);
    import anbs_pkg::*;

    logic    in_fire;
    logic    push;
    logic    full;
    logic    q_valid;
    logic    q_pop;
    group_t  wr_group;
    group_t  rd_group;

    assign s_tready = !full;
    assign in_fire = s_tvalid && !full;

    anbs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .data_byte   (s_tdata[BYTE_W-1:0]),
        .buffer_last (s_tlast),
        .stamp       (s_tdata[BYTE_W+STAMP_W-1:BYTE_W]),
        .push        (push),
        .group       (wr_group)
    );

    anbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_group  (wr_group),
        .pop       (q_pop),
        .full      (full),
        .not_empty (q_valid),
        .rd_group  (rd_group)
    );

    anbs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_group  (rd_group),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
